/* hdl/lsd_pkg.sv */
// ----------------------------------------------------------------------------
// lsd_pkg: shared types and constants for the lifo stack with dump
// operation codes, result status codes and the transfer payload structs
// ----------------------------------------------------------------------------
package lsd_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int WORD_W        = 32;

  typedef enum logic [1:0] {
    FUNC_PUSH  = 2'd0,
    FUNC_DUMP  = 2'd1,
    FUNC_POP   = 2'd2,
    FUNC_CLEAR = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_PUSHED = 3'd0,
    ST_POPPED = 3'd1,
    ST_DUMP   = 3'd2,
    ST_EMPTY  = 3'd3,
    ST_CLEAR  = 3'd4,
    ST_FULL   = 3'd5
  } status_t;

  typedef struct packed {
    func_t                     func;
    logic signed [WORD_W-1:0]  push_value;
  } in_item_t;

  typedef struct packed {
    status_t                   status;
    logic signed [WORD_W-1:0]  out_value;
    logic                      last;
  } out_item_t;

  // per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic push;
    logic pop;
    logic rotate;
  } cell_ctrl_t;

endpackage

/* hdl/lsd_cell.sv */
// ----------------------------------------------------------------------------
// lsd_cell: one storage cell of the stack chain
// holds a single word; shifts down on push, up on pop, and rotates on dump
// ----------------------------------------------------------------------------
module lsd_cell (
  input  logic                                  clk,
  input  lsd_pkg::cell_ctrl_t                   ctrl,
  input  logic                                  is_end,
  input  logic signed [lsd_pkg::WORD_W-1:0]     up_data,
  input  logic signed [lsd_pkg::WORD_W-1:0]     down_data,
  input  logic signed [lsd_pkg::WORD_W-1:0]     wrap_data,
  output logic signed [lsd_pkg::WORD_W-1:0]     data
);
  import lsd_pkg::*;

  logic signed [WORD_W-1:0] data_next;

  always_comb begin
    data_next = data;
    if (ctrl.push) begin
      data_next = up_data;
    end else if (ctrl.pop) begin
      data_next = down_data;
    end else if (ctrl.rotate) begin
      // deepest occupied cell picks up the word leaving the top
      data_next = is_end ? wrap_data : down_data;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

/* hdl/lifo_stack_with_dump_unit.sv */
// ----------------------------------------------------------------------------
// lifo_stack_with_dump_unit: bounded lifo stack of signed words with dump
// push, pop and clear: result in the cycle after the input transfer, one item
// per cycle unless out_ready stalls. dump: enters the dump state, then one
// entry per cycle unless stalled as the cells rotate; the stack ends in order.
// reset empties the stack and the output register; cell contents are kept.
// ----------------------------------------------------------------------------
module lifo_stack_with_dump_unit #(
  parameter int DEPTH = lsd_pkg::DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  lsd_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output lsd_pkg::out_item_t out_data
);
  import lsd_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } state_t;

  state_t                   state;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         remaining;
  logic                     out_free;
  logic                     in_xfer;
  logic                     is_empty;
  logic                     is_full;
  cell_ctrl_t               ctrl;
  logic [DEPTH-1:0]         end_sel;
  logic signed [WORD_W-1:0] cell_q [DEPTH];
  logic                     load;
  out_item_t                out_next;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) && out_free;
  assign in_xfer  = in_valid && in_ready;
  assign is_empty = (count == '0);
  assign is_full  = (count == CNT_W'(DEPTH));

  assign ctrl.push   = in_xfer && (in_data.func == FUNC_PUSH) && !is_full;
  assign ctrl.pop    = in_xfer && (in_data.func == FUNC_POP) && !is_empty;
  assign ctrl.rotate = (state == S_DUMP) && out_free;

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic signed [WORD_W-1:0] up_d;
      logic signed [WORD_W-1:0] down_d;

      assign end_sel[gi] = (count == CNT_W'(gi + 1));

      if (gi == 0) begin : g_top
        assign up_d = in_data.push_value;
      end else begin : g_mid_up
        assign up_d = cell_q[gi-1];
      end

      if (gi == DEPTH - 1) begin : g_bottom
        assign down_d = '0;
      end else begin : g_mid_down
        assign down_d = cell_q[gi+1];
      end

      lsd_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .is_end    (end_sel[gi]),
        .up_data   (up_d),
        .down_data (down_d),
        .wrap_data (cell_q[0]),
        .data      (cell_q[gi])
      );
    end
  endgenerate

  // result for the current cycle, if any
  always_comb begin
    load               = 1'b0;
    out_next.status    = ST_EMPTY;
    out_next.out_value = '0;
    out_next.last      = 1'b1;
    if (ctrl.rotate) begin
      load               = 1'b1;
      out_next.status    = ST_DUMP;
      out_next.out_value = cell_q[0];
      out_next.last      = (remaining == CNT_W'(1));
    end else if (in_xfer) begin
      case (in_data.func)
        FUNC_PUSH: begin
          load            = 1'b1;
          out_next.status = is_full ? ST_FULL : ST_PUSHED;
        end
        FUNC_POP: begin
          load               = 1'b1;
          out_next.status    = is_empty ? ST_EMPTY : ST_POPPED;
          out_next.out_value = is_empty ? '0 : cell_q[0];
        end
        FUNC_CLEAR: begin
          load            = 1'b1;
          out_next.status = is_empty ? ST_EMPTY : ST_CLEAR;
        end
        FUNC_DUMP: begin
          // non-empty dump loads no result here; its entries come from the dump state
          load = is_empty;
        end
        default: begin
          load = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      remaining <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            case (in_data.func)
              FUNC_PUSH: begin
                if (!is_full) begin
                  count <= count + CNT_W'(1);
                end
              end
              FUNC_POP: begin
                if (!is_empty) begin
                  count <= count - CNT_W'(1);
                end
              end
              FUNC_CLEAR: begin
                count <= '0;
              end
              FUNC_DUMP: begin
                if (!is_empty) begin
                  remaining <= count;
                  state     <= S_DUMP;
                end
              end
              default: begin
                count <= count;
              end
            endcase
          end
        end
        S_DUMP: begin
          if (ctrl.rotate) begin
            remaining <= remaining - CNT_W'(1);
            if (remaining == CNT_W'(1)) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= out_next;
    end
  end

endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for lifo_stack_with_dump_unit
// a directed table covers the empty, full and extreme-value cases, then a
// biased random run alternates filling and draining phases; each result is
// checked against its typed row or a behavioural stack under random sender and receiver idling
// ----------------------------------------------------------------------------
module tb_top;
  import lsd_pkg::*;

  localparam int DEPTH       = DEPTH_DEFAULT;
  localparam int RAND_ITEMS  = 245;
  localparam int LONG_HOLD   = 300;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    func_t             func;
    logic [WORD_W-1:0] value;
    int                reps;
    bit                typed;
    status_t           status;
    logic [WORD_W-1:0] result_value;
  } dir_row_t;

  // typed rows give the single result directly, the rest go to the stack model
  dir_row_t dir_rows [22] = '{
    '{FUNC_POP,   32'h5A5A5A5A, 1,     1'b1, ST_EMPTY,  32'h0},
    '{FUNC_DUMP,  32'h00000000, 1,     1'b1, ST_EMPTY,  32'h0},
    '{FUNC_CLEAR, 32'hFFFFFFFF, 1,     1'b1, ST_EMPTY,  32'h0},
    '{FUNC_PUSH,  32'h7FFFFFFF, 1,     1'b1, ST_PUSHED, 32'h0},
    '{FUNC_PUSH,  32'h80000000, 1,     1'b1, ST_PUSHED, 32'h0},
    '{FUNC_DUMP,  32'h00000000, 1,     1'b0, ST_DUMP,   32'h0},
    '{FUNC_POP,   32'h00000000, 1,     1'b1, ST_POPPED, 32'h80000000},
    '{FUNC_POP,   32'hFFFFFFFF, 1,     1'b1, ST_POPPED, 32'h7FFFFFFF},
    '{FUNC_POP,   32'h00000000, 1,     1'b1, ST_EMPTY,  32'h0},
    '{FUNC_PUSH,  32'h00000000, 1,     1'b1, ST_PUSHED, 32'h0},
    '{FUNC_CLEAR, 32'h00000000, 1,     1'b1, ST_CLEAR,  32'h0},
    '{FUNC_PUSH,  32'hA5A5A5A0, DEPTH, 1'b0, ST_PUSHED, 32'h0},
    '{FUNC_PUSH,  32'h12345678, 1,     1'b1, ST_FULL,   32'h0},
    '{FUNC_DUMP,  32'h00000000, 1,     1'b0, ST_DUMP,   32'h0},
    '{FUNC_PUSH,  32'hFFFFFFFF, 1,     1'b1, ST_FULL,   32'h0},
    '{FUNC_POP,   32'h00000000, 1,     1'b0, ST_POPPED, 32'h0},
    '{FUNC_PUSH,  32'hFFFFFFFF, 1,     1'b1, ST_PUSHED, 32'h0},
    '{FUNC_DUMP,  32'h00000000, 1,     1'b0, ST_DUMP,   32'h0},
    '{FUNC_CLEAR, 32'h00000000, 1,     1'b1, ST_CLEAR,  32'h0},
    '{FUNC_DUMP,  32'h00000000, 1,     1'b1, ST_EMPTY,  32'h0},
    '{FUNC_PUSH,  32'hFFFFFFFF, 1,     1'b1, ST_PUSHED, 32'h0},
    '{FUNC_POP,   32'h00000000, 1,     1'b1, ST_POPPED, 32'hFFFFFFFF}
  };

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // side band travelling with each offered item
  logic      row_typed = 1'b0;
  out_item_t row_result = '0;

  logic signed [WORD_W-1:0] stack_words [DEPTH];
  int        stack_fill = 0;
  out_item_t op_results [$];
  out_item_t pending_results [$];

  int  error_count   = 0;
  int  items_taken   = 0;
  int  results_seen  = 0;
  int  dump_entries  = 0;
  int  full_drops    = 0;
  int  empty_replies = 0;
  int  cycle_count   = 0;
  int  burst_left    = 0;
  bit  hold_rx_req   = 1'b0;

  lifo_stack_with_dump_unit #(.DEPTH(DEPTH)) DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // behavioural stack: fills op_results with the results of one operation
  function automatic void apply_stack_op(in_item_t item);
    out_item_t r;
    op_results.delete();
    r = '{status: ST_EMPTY, out_value: '0, last: 1'b1};
    case (item.func)
      FUNC_PUSH: begin
        if (stack_fill == DEPTH) begin
          r.status = ST_FULL;
        end else begin
          stack_words[stack_fill] = item.push_value;
          stack_fill++;
          r.status = ST_PUSHED;
        end
      end
      FUNC_POP: begin
        if (stack_fill != 0) begin
          stack_fill--;
          r.status    = ST_POPPED;
          r.out_value = stack_words[stack_fill];
        end
      end
      FUNC_CLEAR: begin
        if (stack_fill != 0) begin
          stack_fill = 0;
          r.status   = ST_CLEAR;
        end
      end
      FUNC_DUMP: begin
        // top to bottom, last flag on the bottom entry
        for (int i = stack_fill - 1; i >= 0; i--) begin
          r.status    = ST_DUMP;
          r.out_value = stack_words[i];
          r.last      = (i == 0);
          op_results.push_back(r);
        end
      end
    endcase
    if (op_results.size() == 0) op_results.push_back(r);
  endfunction

  task automatic check_result(out_item_t got);
    out_item_t want;
    results_seen++;
    if (pending_results.size() == 0) begin
      $error("result with nothing pending: status %0d out_value %0d last %0d",
             got.status, got.out_value, got.last);
      error_count++;
      return;
    end
    want = pending_results.pop_front();
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      error_count++;
    end
    if (got.out_value !== want.out_value) begin
      $error("out_value: expected %0d, got %0d", want.out_value, got.out_value);
      error_count++;
    end
    if (got.last !== want.last) begin
      $error("last: expected %0d, got %0d", want.last, got.last);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      items_taken++;
      apply_stack_op(in_data);
      foreach (op_results[i]) begin
        if (op_results[i].status == ST_DUMP) dump_entries++;
        if (op_results[i].status == ST_FULL) full_drops++;
        if (op_results[i].status == ST_EMPTY) empty_replies++;
      end
      if (row_typed) pending_results.push_back(row_result);
      else pending_results = {pending_results, op_results};
    end
    if (!rst && out_valid && out_ready) check_result(out_data);
  end

  // receiver: random stall modes, plus one long hold on request
  initial begin : rx_side
    int mode;
    int mode_left;
    int stall_left;
    mode       = 0;
    mode_left  = 0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_rx_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(posedge clk);
        hold_rx_req = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(30, 150);
        end
        mode_left--;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= $urandom_range(0, 1);
          2: out_ready <= ($urandom_range(0, 5) != 0);
          default: begin
            if (stall_left > 0) begin
              stall_left--;
              out_ready <= 1'b0;
            end else if ($urandom_range(0, 7) == 0) begin
              stall_left = $urandom_range(2, 20);
              out_ready <= 1'b0;
            end else begin
              out_ready <= 1'b1;
            end
          end
        endcase
      end
    end
  end

  // sender: bursts of random length with random gaps in between
  task automatic offer_item(in_item_t item, bit typed, out_item_t typed_result);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid   <= 1'b1;
    in_data    <= item;
    row_typed  <= typed;
    row_result <= typed_result;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic [WORD_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return $urandom_range(0, 15);
      3: return -$urandom_range(1, 15);
      default: return $urandom();
    endcase
  endfunction

  initial begin : timeout_watch
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("run stopped at the cycle limit, %0d results still pending",
             pending_results.size());
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    in_item_t  item;
    out_item_t typed_result;
    int        pick;
    int        push_pct;
    int        phase_left;
    bit        fill_phase;
    int        directed_items;

    fill_phase     = 1'b1;
    phase_left     = 0;
    directed_items = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[r]) begin
      for (int k = 0; k < dir_rows[r].reps; k++) begin
        item.func       = dir_rows[r].func;
        item.push_value = dir_rows[r].value ^ k;
        typed_result    = '{status: dir_rows[r].status,
                            out_value: dir_rows[r].result_value, last: 1'b1};
        offer_item(item, dir_rows[r].typed, typed_result);
        directed_items++;
      end
    end

    typed_result = '0;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == 90) begin
        // let the pipeline drain completely before going on
        in_valid   <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (pending_results.size() != 0);
      end
      if (n == 180) hold_rx_req = 1'b1;
      if (phase_left == 0) begin
        fill_phase = ~fill_phase;
        phase_left = $urandom_range(15, 40);
      end
      phase_left--;
      push_pct = fill_phase ? 65 : 25;
      pick = $urandom_range(0, 99);
      if (pick < push_pct) item.func = FUNC_PUSH;
      else if (pick < push_pct + 14) item.func = FUNC_DUMP;
      else if (pick < push_pct + 19) item.func = FUNC_CLEAR;
      else item.func = FUNC_POP;
      item.push_value = pick_value();
      offer_item(item, 1'b0, typed_result);
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (2 * DEPTH + 8) @(posedge clk);

    $display("%0d items (%0d directed) gave %0d results in %0d cycles",
             items_taken, directed_items, results_seen, cycle_count);
    $display("%0d dump entries, %0d full drops, %0d empty replies, %0d errors",
             dump_entries, full_drops, empty_replies, error_count);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
